[hdl/vr2d_pkg.sv]
package vr2d_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W = 52;

    localparam logic [29:0] PHASE_PER_RAD = 30'd683565276;
    localparam logic [29:0] PHASE_PER_DEG = 30'd11930465;

    typedef logic [1:0] quad_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic [WORD_W-1:0]        phase;
    } front_word_t;

    function automatic logic [31:0] atan_phase(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'd536870912;
                1: t = 32'd316933406;
                2: t = 32'd167458907;
                3: t = 32'd85004756;
                4: t = 32'd42667331;
                5: t = 32'd21354465;
                6: t = 32'd10679838;
                7: t = 32'd5340245;
                8: t = 32'd2670163;
                9: t = 32'd1335087;
                10: t = 32'd667544;
                11: t = 32'd333772;
                12: t = 32'd166886;
                13: t = 32'd83443;
                14: t = 32'd41722;
                15: t = 32'd20861;
                16: t = 32'd10430;
                17: t = 32'd5215;
                18: t = 32'd2608;
                19: t = 32'd1304;
                20: t = 32'd652;
                21: t = 32'd326;
                22: t = 32'd163;
                23: t = 32'd81;
                24: t = 32'd41;
                25: t = 32'd20;
                26: t = 32'd10;
                27: t = 32'd5;
                28: t = 32'd3;
                29: t = 32'd1;
                30: t = 32'd1;
                default: t = 32'd0;
            endcase
            return t;
        end
    endfunction

    function automatic logic [31:0] inv_gain(input int n);
        logic [31:0] g;
        begin
            case (n)
                9: g = 32'd652034532;
                10: g = 32'd652033289;
                11: g = 32'd652032978;
                12: g = 32'd652032900;
                13: g = 32'd652032881;
                14: g = 32'd652032876;
                15: g = 32'd652032874;
                default: g = (n <= 8) ? 32'd652039507 : 32'd652032874;
            endcase
            return g;
        end
    endfunction

endpackage

[hdl/vr2d_front.sv]
module vr2d_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [31:0]                 x_in,
    input  logic signed [31:0]                 y_in,
    input  logic signed [31:0]                 turn_angle,
    input  logic                               angle_in_degrees,
    input  logic                               stall,
    output logic                               out_valid,
    output vr2d_pkg::front_word_t              out_word
);

    logic                  v1_reg;
    logic signed [61:0]    prod_reg;
    logic signed [31:0]    x1_reg;
    logic signed [31:0]    y1_reg;
    logic                  v2_reg;
    vr2d_pkg::front_word_t w2_reg;
    logic [31:0]           phase;

    assign phase = prod_reg[47:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (!stall)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            prod_reg <= turn_angle * $signed({1'b0, angle_in_degrees ?
                vr2d_pkg::PHASE_PER_DEG : vr2d_pkg::PHASE_PER_RAD});
            x1_reg <= x_in;
            y1_reg <= y_in;
            w2_reg.x <= x1_reg;
            w2_reg.y <= y1_reg;
            w2_reg.phase <= phase;
        end
    end

    assign out_valid = v2_reg;
    assign out_word = w2_reg;

endmodule

[hdl/vr2d_queue.sv]
module vr2d_queue #(
    parameter int W = 96,
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]   mem_reg [DEPTH];
    logic [AW-1:0]  wp_reg;
    logic [AW-1:0]  rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != '0);
    assign count = cnt_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == ($clog2(DEPTH+1))'(DEPTH)) |-> (!wr || rd))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd |-> not_empty)
        else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("count step");

endmodule

[hdl/vr2d_back.sv]
module vr2d_back #(
    parameter int STAGES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  vr2d_pkg::front_word_t in_word,
    input  logic                  stall,
    output logic                  out_valid,
    output logic signed [31:0]    x_out,
    output logic signed [31:0]    y_out,
    output logic                  saturated
);

    localparam int N = (STAGES > 32) ? 32 : STAGES;
    localparam int AW = vr2d_pkg::ACC_W;
    localparam logic [31:0] GAIN = vr2d_pkg::inv_gain(STAGES);

    logic                  v0_reg;
    logic signed [32:0]    qx_hold_reg;
    logic signed [32:0]    qy_hold_reg;
    logic [31:0]           r0_reg;
    logic                  vg_reg;
    logic signed [AW-1:0]  gx_reg;
    logic signed [AW-1:0]  gy_reg;
    logic [31:0]           rg_reg;
    logic                  vs_reg [N+1];
    logic signed [AW-1:0]  xs_reg [N+1];
    logic signed [AW-1:0]  ys_reg [N+1];
    logic [31:0]           rs_reg [N+1];
    logic                  vo_reg;
    logic signed [31:0]    xo_reg;
    logic signed [31:0]    yo_reg;
    logic                  so_reg;

    logic [1:0]            q;
    logic [31:0]           ph;
    logic signed [32:0]    x_neg;
    logic signed [32:0]    y_neg;
    logic signed [32:0]    qx;
    logic signed [32:0]    qy;
    logic signed [65:0]    px;
    logic signed [65:0]    py;
    logic signed [AW-1:0]  rx;
    logic signed [AW-1:0]  ry;
    logic                  sat_x;
    logic                  sat_y;
    logic signed [31:0]    cx;
    logic signed [31:0]    cy;

    assign ph = in_word.phase;
    assign q = 2'((ph + 32'h2000_0000) >> 30);
    assign x_neg = -$signed({in_word.x[31], in_word.x});
    assign y_neg = -$signed({in_word.y[31], in_word.y});

    always_comb
    begin
        case (q)
            2'd1:
            begin
                qx = y_neg;
                qy = {in_word.x[31], in_word.x};
            end
            2'd2:
            begin
                qx = x_neg;
                qy = y_neg;
            end
            2'd3:
            begin
                qx = {in_word.y[31], in_word.y};
                qy = x_neg;
            end
            default:
            begin
                qx = {in_word.x[31], in_word.x};
                qy = {in_word.y[31], in_word.y};
            end
        endcase
    end

    assign px = qx_hold_reg * $signed({1'b0, GAIN});
    assign py = qy_hold_reg * $signed({1'b0, GAIN});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vg_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
            begin
                vs_reg[i] <= 1'b0;
            end
        end
        else if (!stall)
        begin
            v0_reg <= in_valid;
            vg_reg <= v0_reg;
            vs_reg[0] <= vg_reg;
            for (int i = 0; i < N; i++)
            begin
                vs_reg[i+1] <= vs_reg[i];
            end
            vo_reg <= vs_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            qx_hold_reg <= qx;
            qy_hold_reg <= qy;
            r0_reg <= ph - {q, 30'd0};
            gx_reg <= AW'(px >>> 16);
            gy_reg <= AW'(py >>> 16);
            rg_reg <= r0_reg;
            xs_reg[0] <= gx_reg;
            ys_reg[0] <= gy_reg;
            rs_reg[0] <= rg_reg;
            for (int i = 0; i < N; i++)
            begin
                if (!rs_reg[i][31])
                begin
                    xs_reg[i+1] <= xs_reg[i] - (ys_reg[i] >>> i);
                    ys_reg[i+1] <= ys_reg[i] + (xs_reg[i] >>> i);
                    rs_reg[i+1] <= rs_reg[i] - vr2d_pkg::atan_phase(i);
                end
                else
                begin
                    xs_reg[i+1] <= xs_reg[i] + (ys_reg[i] >>> i);
                    ys_reg[i+1] <= ys_reg[i] - (xs_reg[i] >>> i);
                    rs_reg[i+1] <= rs_reg[i] + vr2d_pkg::atan_phase(i);
                end
            end
            xo_reg <= cx;
            yo_reg <= cy;
            so_reg <= sat_x | sat_y;
        end
    end

    assign rx = (xs_reg[N] + AW'(8192)) >>> 14;
    assign ry = (ys_reg[N] + AW'(8192)) >>> 14;

    always_comb
    begin
        sat_x = 1'b0;
        sat_y = 1'b0;
        cx = rx[31:0];
        cy = ry[31:0];
        if (rx > AW'(64'sh7FFF_FFFF))
        begin
            sat_x = 1'b1;
            cx = 32'sh7FFF_FFFF;
        end
        else if (rx < -AW'(64'sh8000_0000))
        begin
            sat_x = 1'b1;
            cx = 32'sh8000_0000;
        end
        if (ry > AW'(64'sh7FFF_FFFF))
        begin
            sat_y = 1'b1;
            cy = 32'sh7FFF_FFFF;
        end
        else if (ry < -AW'(64'sh8000_0000))
        begin
            sat_y = 1'b1;
            cy = 32'sh8000_0000;
        end
    end

    assign out_valid = vo_reg;
    assign x_out = xo_reg;
    assign y_out = yo_reg;
    assign saturated = so_reg;

endmodule

[hdl/vector_rotate_2d_top.sv]
// Rotates a signed Q16.16 point (x_in, y_in) by turn_angle, in radians or in
// degrees when angle_in_degrees is set, with a pipelined CORDIC.
// Input words are written with push while full is low.  Each accepted word
// yields exactly one result word, in order, holding x_out, y_out and the
// saturated flag.  A result is on the output ports while empty is low and is
// taken with pop.
// The front pipeline turns the angle into a phase and hands it to a short
// queue.  The back pipeline then does quadrant folding, gain scaling, the
// CORDIC stages and output rounding, and feeds an output queue.  One word is
// accepted every cycle as long as the consumer keeps up.
// When the consumer stalls, words stop leaving the middle queue once the back
// pipeline and the output queue together hold OQ_DEPTH words; the middle
// queue then fills up, and full rises once it holds two words.
// Reset empties both queues and clears every pipeline valid; no words survive.
module vector_rotate_2d_top #(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] turn_angle,
    input  logic               angle_in_degrees,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic               saturated
);

    localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int BACK_LAT = N + 4;
    localparam int OQ_DEPTH = BACK_LAT + 2;
    localparam int OQ_CW = $clog2(OQ_DEPTH + 1);
    localparam int FW = $bits(vr2d_pkg::front_word_t);

    logic                  acc;
    logic                  f_valid;
    vr2d_pkg::front_word_t f_word;
    logic                  mq_ne;
    logic [FW-1:0]         mq_data;
    logic [2:0]            mq_cnt;
    logic                  mq_rd;
    logic                  b_valid;
    logic signed [31:0]    bx;
    logic signed [31:0]    by;
    logic                  bs;
    logic                  oq_ne;
    logic [64:0]           oq_data;
    logic [OQ_CW-1:0]      oq_cnt;
    logic                  b_stall;
    logic [OQ_CW:0]        inflight_reg;

    // Middle queue has room for the two words that may be in the front stages.
    assign full = (mq_cnt >= 3'd2);
    assign acc = push && !full;

    vr2d_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (acc),
        .x_in             (x_in),
        .y_in             (y_in),
        .turn_angle       (turn_angle),
        .angle_in_degrees (angle_in_degrees),
        .stall            (1'b0),
        .out_valid        (f_valid),
        .out_word         (f_word)
    );

    vr2d_queue #(.W(FW), .DEPTH(4)) u_mid_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (f_valid),
        .wdata     (f_word),
        .rd        (mq_rd),
        .rdata     (mq_data),
        .not_empty (mq_ne),
        .count     (mq_cnt)
    );

    // Back pipeline never stalls; words are admitted only with output room.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + (mq_rd ? 1'b1 : 1'b0)
                - (b_valid ? 1'b1 : 1'b0);
        end
    end

    assign b_stall = 1'b0;
    assign mq_rd = mq_ne &&
        ((inflight_reg + (OQ_CW+1)'(oq_cnt)) < (OQ_CW+1)'(OQ_DEPTH));

    vr2d_back #(.STAGES(CORDIC_STAGES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mq_rd),
        .in_word   (vr2d_pkg::front_word_t'(mq_data)),
        .stall     (b_stall),
        .out_valid (b_valid),
        .x_out     (bx),
        .y_out     (by),
        .saturated (bs)
    );

    vr2d_queue #(.W(65), .DEPTH(OQ_DEPTH)) u_out_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (b_valid),
        .wdata     ({bx, by, bs}),
        .rd        (pop && oq_ne),
        .rdata     (oq_data),
        .not_empty (oq_ne),
        .count     (oq_cnt)
    );

    assign empty = !oq_ne;
    assign x_out = oq_data[64:33];
    assign y_out = oq_data[32:1];
    assign saturated = oq_data[0];

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg + (OQ_CW+1)'(oq_cnt)) <= (OQ_CW+1)'(OQ_DEPTH))
        else $error("output credit exceeded");
    a_mid_room: assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> (mq_cnt <= 3'd1))
        else $error("middle queue credit");
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= (OQ_CW+1)'(BACK_LAT))
        else $error("inflight bound");

endmodule

[dv/vector_rotate_2d_top_tb.sv]
module vector_rotate_2d_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 8;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } rotated_word_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] turn_angle;
    logic               angle_in_degrees;
    logic               empty;
    logic               pop;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic               saturated;

    int error_count = 0;
    int pushed_count = 0;
    int popped_count = 0;
    int sat_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    vector_rotate_2d_top #(.CORDIC_STAGES(STAGES)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .x_in(x_in), .y_in(y_in), .turn_angle(turn_angle),
        .angle_in_degrees(angle_in_degrees), .empty(empty), .pop(pop),
        .x_out(x_out), .y_out(y_out), .saturated(saturated)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on word %0d: %s got %0d expected %0d", popped_count, what, got, want);
        error_count++;
    endtask

    function automatic longint floor_div(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] round_clamp(input longint v, inout logic sat);
        longint r;
        r = floor_div(v + (64'sd1 <<< 13), 14);
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            r = 64'sd2147483647;
        end else if (r < -64'sd2147483648) begin
            sat = 1'b1;
            r = -64'sd2147483648;
        end
        return r[31:0];
    endfunction

    function automatic longint arc_step(input int i);
        longint steps[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
            20, 10, 5, 3, 1, 1, 0};
        return steps[i];
    endfunction

    function automatic rotated_word_t rotate_point(input logic signed [31:0] px,
        input logic signed [31:0] py, input logic signed [31:0] ang, input logic deg);
        longint x, y, t, r, dx, dy, prod, gain;
        longint short_gain[8] = '{652039507, 652034532, 652033289, 652032978,
            652032900, 652032881, 652032876, 652032874};
        logic [31:0] phase;
        logic [1:0]  quad;
        logic [31:0] resid;
        logic        sat;
        rotated_word_t res;
        x = longint'(px);
        y = longint'(py);
        prod = longint'(ang) * (deg ? 64'sd11930465 : 64'sd683565276);
        phase = prod[47:16];
        quad = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {quad, 30'd0};
        r = longint'(signed'(resid));
        case (quad)
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        if (STAGES >= 16) gain = 652032874;
        else if (STAGES <= 8) gain = short_gain[0];
        else gain = short_gain[(STAGES - 8) & 7];
        x = floor_div(x * gain, 16);
        y = floor_div(y * gain, 16);
        for (int i = 0; i < (STAGES > 32 ? 32 : STAGES); i++) begin
            dx = floor_div(y, i);
            dy = floor_div(x, i);
            if (r >= 0) begin
                x = x - dx; y = y + dy; r = r - arc_step(i);
            end else begin
                x = x + dx; y = y - dy; r = r + arc_step(i);
            end
        end
        sat = 1'b0;
        res.x = round_clamp(x, sat);
        res.y = round_clamp(y, sat);
        res.sat = sat;
        return res;
    endfunction

    class rotation_scoreboard;
        rotated_word_t pending[$];

        function void note_input(logic signed [31:0] px, logic signed [31:0] py,
            logic signed [31:0] ang, logic deg);
            pending.push_back(rotate_point(px, py, ang, deg));
        endfunction

        task check_result(logic signed [31:0] gx, logic signed [31:0] gy, logic gs);
            rotated_word_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word, x_out", gx, 0);
            end else begin
                want = pending.pop_front();
                if (gx !== want.x) report_mismatch("x_out", gx, want.x);
                if (gy !== want.y) report_mismatch("y_out", gy, want.y);
                if (gs !== want.sat) report_mismatch("saturated", gs, want.sat);
            end
        endtask
    endclass

    rotation_scoreboard board;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] ang, input logic deg);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        x_in <= px;
        y_in <= py;
        turn_angle <= ang;
        angle_in_degrees <= deg;
        do @(posedge clk); while (full);
        board.note_input(px, py, ang, deg);
        pushed_count++;
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        logic signed [31:0] px, py, ang;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(3);
            px = $urandom;
            py = $urandom;
            if (kind != 0) begin
                px = $signed(px) >>> $urandom_range(20, 8);
                py = $signed(py) >>> $urandom_range(20, 8);
            end
            ang = $urandom;
            if (kind == 1) ang = $signed(ang) >>> $urandom_range(24, 10);
            send_point(px, py, ang, $urandom_range(1));
        end
    endtask

    task automatic drain_wait();
        push <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty) begin
            board.check_result(x_out, y_out, saturated);
            popped_count++;
            if (saturated) sat_count++;
        end
    end

    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        logic signed [31:0] edge_vals[6] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, -1,
            32'sh0001_0000};
        board = new();
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        x_in = '0;
        y_in = '0;
        turn_angle = '0;
        angle_in_degrees = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int i = 0; i < 6; i++)
            send_point(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6], i[0]);
        send_point(32'sh0001_0000, 0, 32'sd90 <<< 16, 1'b1);
        send_point(32'sh0001_0000, 0, 32'sd180 <<< 16, 1'b1);
        send_point(32'sh0001_0000, 0, -32'sd90 <<< 16, 1'b1);
        send_point(32'sh0001_0000, 32'sh0002_0000, 32'sd45 <<< 16, 1'b1);
        send_point(32'sh0001_0000, 0, 32'sh0003_243F, 1'b0);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd45 <<< 16, 1'b1);
        send_point(32'sh8000_0000, 32'sh8000_0000, -32'sd45 <<< 16, 1'b1);
        send_point(32'sh4000_0000, 32'shC000_0000, 32'sh7FFF_FFFF, 1'b0);
        drain_wait();
        send_random(450);
        idle_pct = 59;
        send_random(450);
        drain_wait();
        idle_pct = 0;
        stall_pct = 59;
        send_random(430);
        idle_pct = 27;
        stall_pct = 27;
        send_random(420);
        drain_wait();
        repeat (LATENCY + 4) @(negedge clk);
        $display("Rotated %0d points across four handshake pressure phases, %0d saturated.",
            pushed_count, sat_count);
        if (error_count == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule

[filelist.f]
hdl/vr2d_pkg.sv
hdl/vr2d_front.sv
hdl/vr2d_queue.sv
hdl/vr2d_back.sv
hdl/vector_rotate_2d_top.sv
dv/vector_rotate_2d_top_tb.sv
